[hdl/pewma_pkg.sv]
// Package for the pressure EWMA block: widths, reset values, register map,
// sequencer states. Used by pressure_ewma_with_offset_calibration.
package pewma_pkg;

  localparam int AdcBits    = 12;
  localparam int CalSamples = 16;

  localparam int SampleW = 12;
  localparam int MvW     = 16;
  localparam int SfW     = 9;
  localparam int PressW  = 8;
  localparam int CntW    = 8;
  localparam int AccW    = 34;
  localparam int StepW   = 4;
  localparam int AddrW   = 5;
  localparam int DataW   = 32;
  localparam int MvShift = AdcBits - 8;

  localparam logic [SfW-1:0] SfOne    = SfW'(256);
  localparam logic [SfW-1:0] SfReset  = SfW'(90);
  localparam logic [MvW-1:0] SensReset = MvW'(1485);
  localparam logic [MvW-1:0] SupReset  = MvW'(5000);
  localparam logic [MvW-1:0] LowReset  = MvW'(0);
  localparam logic [MvW-1:0] HighReset = MvW'(425);
  localparam logic [AccW-1:0] RoundHalf = AccW'(32768);

  typedef enum logic [2:0] {
    RegSmooth = 3'd0,
    RegSens   = 3'd1,
    RegSupply = 3'd2,
    RegLow    = 3'd3,
    RegHigh   = 3'd4
  } reg_idx_e;

  typedef enum logic [6:0] {
    StIdle   = 7'b0000001,
    StMulMv  = 7'b0000010,
    StMulNew = 7'b0000100,
    StMulOld = 7'b0001000,
    StCur    = 7'b0010000,
    StMulP   = 7'b0100000,
    StDone   = 7'b1000000
  } state_e;

endpackage

[hdl/pressure_ewma_with_offset_calibration.sv]
// Pressure EWMA filter with start-up offset calibration, APB register port.
// A new sample is taken only in the idle state, after the previous result is handed off.
// One shift-add unit takes one multiplier bit per cycle: 12 bits for the
// conversion, 9 + 9 for the filter weights, 16 for the sensitivity.
// Reset (rst_ni low, async): register defaults; filter, offset, count, flags cleared.
// Depends on pewma_pkg.
module pressure_ewma_with_offset_calibration (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pewma_pkg::AddrW-1:0]   paddr,
  input  logic [pewma_pkg::DataW-1:0]   pwdata,
  output logic [pewma_pkg::DataW-1:0]   prdata,
  output logic                          pready,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [pewma_pkg::SampleW-1:0] adc_sample_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [pewma_pkg::PressW-1:0]  pressure_o,
  output logic [pewma_pkg::MvW-1:0]     filtered_millivolts_o,
  output logic                          ready_res_o,
  output logic                          offset_fault_o
);

  logic [pewma_pkg::SfW-1:0] sf_q;
  logic [pewma_pkg::MvW-1:0] sens_q, sup_q, low_q, high_q;

  pewma_pkg::state_e state_q, state_d;
  logic [pewma_pkg::AccW-1:0]  acc_q, acc_d, mcand_q, mcand_d, acc_step;
  logic [pewma_pkg::MvW-1:0]   mplier_q, mplier_d;
  logic [pewma_pkg::StepW-1:0] step_q, step_d;
  logic [pewma_pkg::MvW-1:0]   smooth_q, smooth_d, off_q, off_d, cur_q, cur_d;
  logic [pewma_pkg::CntW-1:0]  cnt_q, cnt_d, cnt_inc;
  logic                        cal_q, cal_d, fault_q, fault_d, neg_q, neg_d;
  logic                        oval_q, oval_d;
  logic [pewma_pkg::PressW-1:0] pres_q, pres_d, pres_calc;
  logic [pewma_pkg::MvW-1:0]   ofilt_q, ofilt_d;
  logic                        ordy_q, ordy_d, ofault_q, ofault_d;

  logic [pewma_pkg::SfW-1:0] wt_new, wt_old;
  logic [pewma_pkg::MvW-1:0] cur_sat, diff;
  logic                      cur_neg, last_step, cfg_wr;
  logic [2:0]                reg_idx;

  // Register port
  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign reg_idx = paddr[4:2];

  always_comb begin
    prdata = '0;
    case (reg_idx)
      pewma_pkg::RegSmooth: prdata = pewma_pkg::DataW'(sf_q);
      pewma_pkg::RegSens:   prdata = pewma_pkg::DataW'(sens_q);
      pewma_pkg::RegSupply: prdata = pewma_pkg::DataW'(sup_q);
      pewma_pkg::RegLow:    prdata = pewma_pkg::DataW'(low_q);
      pewma_pkg::RegHigh:   prdata = pewma_pkg::DataW'(high_q);
      default:              prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sf_q   <= pewma_pkg::SfReset;
      sens_q <= pewma_pkg::SensReset;
      sup_q  <= pewma_pkg::SupReset;
      low_q  <= pewma_pkg::LowReset;
      high_q <= pewma_pkg::HighReset;
    end else if (cfg_wr) begin
      case (reg_idx)
        pewma_pkg::RegSmooth: sf_q   <= pwdata[pewma_pkg::SfW-1:0];
        pewma_pkg::RegSens:   sens_q <= pwdata[pewma_pkg::MvW-1:0];
        pewma_pkg::RegSupply: sup_q  <= pwdata[pewma_pkg::MvW-1:0];
        pewma_pkg::RegLow:    low_q  <= pwdata[pewma_pkg::MvW-1:0];
        pewma_pkg::RegHigh:   high_q <= pwdata[pewma_pkg::MvW-1:0];
        default: ;
      endcase
    end
  end

  // Datapath helpers
  assign wt_new    = (sf_q > pewma_pkg::SfOne) ? pewma_pkg::SfOne : sf_q;
  assign wt_old    = pewma_pkg::SfOne - wt_new;
  assign acc_step  = acc_q + (mplier_q[0] ? mcand_q : '0);
  assign last_step = (step_q == '0);

  assign cur_sat = (acc_q[pewma_pkg::AccW-1:32] != '0) ? '1 : acc_q[31:16];
  assign cur_neg = cur_sat < off_q;
  assign diff    = cur_neg ? (off_q - cur_sat) : (cur_sat - off_q);
  assign cnt_inc = (cnt_q != '1) ? cnt_q + 1'b1 : cnt_q;

  assign pres_calc = neg_q ? '0 :
                     (acc_q[pewma_pkg::AccW-1:24] != '0) ? '1 : acc_q[23:16];

  always_comb begin
    state_d  = state_q;
    acc_d    = acc_q;
    mcand_d  = mcand_q;
    mplier_d = mplier_q;
    step_d   = step_q;
    smooth_d = smooth_q;
    off_d    = off_q;
    cur_d    = cur_q;
    cnt_d    = cnt_q;
    cal_d    = cal_q;
    fault_d  = fault_q;
    neg_d    = neg_q;
    oval_d   = oval_q & ~out_ready_i;
    pres_d   = pres_q;
    ofilt_d  = ofilt_q;
    ordy_d   = ordy_q;
    ofault_d = ofault_q;

    case (state_q)
      pewma_pkg::StIdle: begin
        if (in_valid_i) begin
          acc_d    = '0;
          mcand_d  = pewma_pkg::AccW'(sup_q);
          mplier_d = pewma_pkg::MvW'(adc_sample_i);
          step_d   = pewma_pkg::StepW'(pewma_pkg::SampleW - 1);
          state_d  = pewma_pkg::StMulMv;
        end
      end
      pewma_pkg::StMulMv: begin
        acc_d    = acc_step;
        mcand_d  = mcand_q << 1;
        mplier_d = mplier_q >> 1;
        step_d   = step_q - 1'b1;
        if (last_step) begin
          // mv in Q.8 = product * 256 / 2^AdcBits
          mcand_d  = acc_step >> pewma_pkg::MvShift;
          acc_d    = '0;
          mplier_d = pewma_pkg::MvW'(wt_new);
          step_d   = pewma_pkg::StepW'(pewma_pkg::SfW - 1);
          state_d  = pewma_pkg::StMulNew;
        end
      end
      pewma_pkg::StMulNew: begin
        acc_d    = acc_step;
        mcand_d  = mcand_q << 1;
        mplier_d = mplier_q >> 1;
        step_d   = step_q - 1'b1;
        if (last_step) begin
          mcand_d  = pewma_pkg::AccW'(smooth_q) << 8;
          mplier_d = pewma_pkg::MvW'(wt_old);
          step_d   = pewma_pkg::StepW'(pewma_pkg::SfW - 1);
          state_d  = pewma_pkg::StMulOld;
        end
      end
      pewma_pkg::StMulOld: begin
        acc_d    = acc_step;
        mcand_d  = mcand_q << 1;
        mplier_d = mplier_q >> 1;
        step_d   = step_q - 1'b1;
        if (last_step) state_d = pewma_pkg::StCur;
      end
      pewma_pkg::StCur: begin
        cur_d    = cur_sat;
        neg_d    = cur_neg;
        smooth_d = cur_sat;
        acc_d    = pewma_pkg::RoundHalf;
        mcand_d  = pewma_pkg::AccW'(diff);
        mplier_d = sens_q;
        step_d   = pewma_pkg::StepW'(pewma_pkg::MvW - 1);
        state_d  = pewma_pkg::StMulP;
        if (!cal_q) begin
          cnt_d = cnt_inc;
          if (cnt_inc >= pewma_pkg::CntW'(pewma_pkg::CalSamples)) begin
            off_d    = cur_sat;
            smooth_d = '0;
            cal_d    = 1'b1;
            if (cur_sat < low_q || cur_sat > high_q) fault_d = 1'b1;
          end
        end
      end
      pewma_pkg::StMulP: begin
        acc_d    = acc_step;
        mcand_d  = mcand_q << 1;
        mplier_d = mplier_q >> 1;
        step_d   = step_q - 1'b1;
        if (last_step) state_d = pewma_pkg::StDone;
      end
      pewma_pkg::StDone: begin
        if (!oval_q || out_ready_i) begin
          oval_d   = 1'b1;
          pres_d   = pres_calc;
          ofilt_d  = cur_q;
          ordy_d   = cal_q;
          ofault_d = fault_q;
          state_d  = pewma_pkg::StIdle;
        end
      end
      default: state_d = pewma_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= pewma_pkg::StIdle;
      smooth_q <= '0;
      off_q    <= '0;
      cnt_q    <= '0;
      cal_q    <= 1'b0;
      fault_q  <= 1'b0;
      oval_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      smooth_q <= smooth_d;
      off_q    <= off_d;
      cnt_q    <= cnt_d;
      cal_q    <= cal_d;
      fault_q  <= fault_d;
      oval_q   <= oval_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q    <= acc_d;
    mcand_q  <= mcand_d;
    mplier_q <= mplier_d;
    step_q   <= step_d;
    cur_q    <= cur_d;
    neg_q    <= neg_d;
    pres_q   <= pres_d;
    ofilt_q  <= ofilt_d;
    ordy_q   <= ordy_d;
    ofault_q <= ofault_d;
  end

  assign in_ready_o            = (state_q == pewma_pkg::StIdle);
  assign out_valid_o           = oval_q;
  assign pressure_o            = pres_q;
  assign filtered_millivolts_o = ofilt_q;
  assign ready_res_o           = ordy_q;
  assign offset_fault_o        = ofault_q;

  a_cal_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cal_q |=> cal_q) else $error("calibration flag dropped");

  a_fault_needs_cal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fault_q |-> cal_q) else $error("fault flag set before calibration");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cal_q |-> (cnt_q < pewma_pkg::CntW'(pewma_pkg::CalSamples)))
    else $error("calibration count overran while uncalibrated");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("item accepted while sequencer stayed idle");

  a_out_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (!offset_fault_o || ready_res_o))
    else $error("fault shown without ready");

endmodule

[tb/pressure_ewma_with_offset_calibration_test.sv]
// Self-checking testbench for pressure_ewma_with_offset_calibration: calibration,
// EWMA filtering and pressure scaling checked per item against a local predictor.
// Depends on pewma_pkg and the block's RTL.
module pressure_ewma_with_offset_calibration_test;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [pewma_pkg::PressW-1:0] pressure;
    logic [pewma_pkg::MvW-1:0]    millivolts;
    logic                         calibrated;
    logic                         fault;
  } pressure_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                            psel = 1'b0;
  logic                            penable = 1'b0;
  logic                            pwrite = 1'b0;
  logic [pewma_pkg::AddrW-1:0]     paddr = '0;
  logic [pewma_pkg::DataW-1:0]     pwdata = '0;
  logic [pewma_pkg::DataW-1:0]     prdata;
  logic                            pready;
  logic                            in_valid = 1'b0;
  logic                            in_ready;
  logic [pewma_pkg::SampleW-1:0]   adc_sample = '0;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  logic [pewma_pkg::PressW-1:0]    pressure;
  logic [pewma_pkg::MvW-1:0]       filtered_mv;
  logic                            ready_res;
  logic                            offset_fault;

  // predictor copy of registers and state
  logic [pewma_pkg::SfW-1:0]  cfg_weight = 9'd90;
  logic [pewma_pkg::MvW-1:0]  cfg_sens = 16'd1485;
  logic [pewma_pkg::MvW-1:0]  cfg_supply = 16'd5000;
  logic [pewma_pkg::MvW-1:0]  cfg_low = 16'd0;
  logic [pewma_pkg::MvW-1:0]  cfg_high = 16'd425;
  logic [pewma_pkg::MvW-1:0]  smooth_mv = '0;
  logic [pewma_pkg::MvW-1:0]  zero_mv = '0;
  logic [pewma_pkg::CntW-1:0] cal_count = '0;
  logic                       cal_done = 1'b0;
  logic                       fault_seen = 1'b0;

  logic [pewma_pkg::SampleW-1:0] sample_q[$];
  pressure_res_t      expected_q[$];
  int  sent_total = 0;
  int  results_done = 0;
  int  errors = 0;
  bit  idle_on = 1'b0;
  bit  hold_done = 1'b0;
  int  hold_left = 0;
  int  send_gap = 0;
  int  stall_left = 0;
  logic in_taken = 1'b0;

  pressure_ewma_with_offset_calibration uut (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .psel                  (psel),
    .penable               (penable),
    .pwrite                (pwrite),
    .paddr                 (paddr),
    .pwdata                (pwdata),
    .prdata                (prdata),
    .pready                (pready),
    .in_valid_i            (in_valid),
    .in_ready_o            (in_ready),
    .adc_sample_i          (adc_sample),
    .out_valid_o           (out_valid),
    .out_ready_i           (out_ready),
    .pressure_o            (pressure),
    .filtered_millivolts_o (filtered_mv),
    .ready_res_o           (ready_res),
    .offset_fault_o        (offset_fault)
  );

  always #2 clk_i = ~clk_i;

  function automatic pressure_res_t filter_sample(logic [pewma_pkg::SampleW-1:0] sample);
    logic [63:0] mv_q8;
    logic [63:0] weight;
    logic [63:0] acc;
    logic [63:0] mag;
    logic [pewma_pkg::MvW-1:0] cur;
    pressure_res_t res;
    mv_q8 = ((64'(sample) * 64'(cfg_supply)) << 8) >> pewma_pkg::AdcBits;
    weight = (cfg_weight > 9'd256) ? 64'd256 : 64'(cfg_weight);
    acc = (64'd256 - weight) * 64'(smooth_mv) * 64'd256 + weight * mv_q8;
    cur = ((acc >> 16) > 64'hFFFF) ? 16'hFFFF : acc[31:16];
    smooth_mv = cur;
    if (cur < zero_mv) begin
      res.pressure = '0;
    end else begin
      mag = (64'(cur - zero_mv) * 64'(cfg_sens) + 64'd32768) >> 16;
      res.pressure = (mag > 64'd255) ? 8'd255 : mag[7:0];
    end
    if (!cal_done) begin
      if (cal_count != 8'd255) cal_count = cal_count + 8'd1;
      if (cal_count >= pewma_pkg::CntW'(pewma_pkg::CalSamples)) begin
        zero_mv = cur;
        smooth_mv = '0;
        if (cur < cfg_low || cur > cfg_high) fault_seen = 1'b1;
        cal_done = 1'b1;
      end
    end
    res.millivolts = cur;
    res.calibrated = cal_done;
    res.fault = fault_seen;
    return res;
  endfunction

  // sender: one item per handshake, random gap bursts
  always @(negedge clk_i) begin
    logic next_valid;
    logic [pewma_pkg::SampleW-1:0] next_sample;
    next_valid = in_valid;
    next_sample = adc_sample;
    if (rst_ni && (!in_valid || in_taken)) begin
      next_valid = 1'b0;
      if (!idle_on) send_gap = 0;
      if (send_gap != 0) begin
        send_gap = send_gap - 1;
      end else if (sample_q.size() != 0) begin
        next_valid = 1'b1;
        next_sample = sample_q.pop_front();
        if (idle_on && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 19);
      end
    end
    in_valid <= next_valid;
    adc_sample <= next_sample;
  end

  // receiver: random stall bursts plus one long hold-off
  always @(negedge clk_i) begin
    logic next_ready;
    next_ready = 1'b1;
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      next_ready = 1'b0;
    end else if (!hold_done && results_done >= 300) begin
      hold_done = 1'b1;
      hold_left = 600;
      next_ready = 1'b0;
    end else if (idle_on) begin
      if (stall_left != 0) begin
        stall_left = stall_left - 1;
        next_ready = 1'b0;
      end else if ($urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 18);
        next_ready = 1'b0;
      end
    end
    out_ready <= next_ready;
  end

  always @(posedge clk_i) begin
    pressure_res_t want;
    in_taken <= in_valid && in_ready;
    if (rst_ni && out_valid && out_ready) begin
      results_done <= results_done + 1;
      if (expected_q.size() == 0) begin
        $error("unexpected result item: pressure %0d, filtered %0d", pressure, filtered_mv);
        errors++;
      end else begin
        want = expected_q.pop_front();
        if (pressure !== want.pressure) begin
          $error("pressure: expected %0d, actual %0d", want.pressure, pressure);
          errors++;
        end
        if (filtered_mv !== want.millivolts) begin
          $error("filtered_millivolts: expected %0d, actual %0d", want.millivolts, filtered_mv);
          errors++;
        end
        if (ready_res !== want.calibrated) begin
          $error("ready_res: expected %0d, actual %0d", want.calibrated, ready_res);
          errors++;
        end
        if (offset_fault !== want.fault) begin
          $error("offset_fault: expected %0d, actual %0d", want.fault, offset_fault);
          errors++;
        end
      end
    end
    if (rst_ni && in_valid && in_ready) expected_q.push_back(filter_sample(adc_sample));
  end

  task automatic cfg_write(pewma_pkg::reg_idx_e idx, logic [pewma_pkg::DataW-1:0] value);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      pewma_pkg::RegSmooth: cfg_weight = value[pewma_pkg::SfW-1:0];
      pewma_pkg::RegSens:   cfg_sens = value[pewma_pkg::MvW-1:0];
      pewma_pkg::RegSupply: cfg_supply = value[pewma_pkg::MvW-1:0];
      pewma_pkg::RegLow:    cfg_low = value[pewma_pkg::MvW-1:0];
      pewma_pkg::RegHigh:   cfg_high = value[pewma_pkg::MvW-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic queue_sample(logic [pewma_pkg::SampleW-1:0] sample);
    sample_q.push_back(sample);
    sent_total++;
  endtask

  task automatic wait_drained();
    while (results_done != sent_total) @(posedge clk_i);
  endtask

  task automatic random_config();
    logic [pewma_pkg::DataW-1:0] weight;
    logic [pewma_pkg::DataW-1:0] sens;
    logic [pewma_pkg::DataW-1:0] supply;
    case ($urandom_range(0, 5))
      0: weight = 0;
      1: weight = 256;
      2: weight = 511;
      3: weight = $urandom_range(257, 511);
      default: weight = $urandom_range(1, 255);
    endcase
    case ($urandom_range(0, 3))
      0: sens = $urandom_range(0, 1) * 65535;
      1: sens = $urandom_range(0, 65535);
      default: sens = $urandom_range(0, 3000);
    endcase
    case ($urandom_range(0, 3))
      0: supply = $urandom_range(0, 1) * 65535;
      1: supply = $urandom_range(0, 65535);
      default: supply = $urandom_range(3000, 6000);
    endcase
    cfg_write(pewma_pkg::RegSmooth, weight);
    cfg_write(pewma_pkg::RegSens, sens);
    cfg_write(pewma_pkg::RegSupply, supply);
    cfg_write(pewma_pkg::RegLow, $urandom_range(0, 65535));
    cfg_write(pewma_pkg::RegHigh, $urandom_range(0, 65535));
  endtask

  task automatic random_phase(int count, bit idle);
    logic [pewma_pkg::SampleW-1:0] level;
    int k;
    @(posedge clk_i);
    idle_on = idle;
    level = pewma_pkg::SampleW'($urandom_range(0, 4095));
    for (k = 0; k < count; k++) begin
      case ($urandom_range(0, 9))
        0: queue_sample('0);
        1: queue_sample('1);
        2, 3, 4: queue_sample(level ^ pewma_pkg::SampleW'($urandom_range(0, 31)));
        default: queue_sample(pewma_pkg::SampleW'($urandom_range(0, 4095)));
      endcase
    end
    wait_drained();
  endtask

  initial begin
    bit fault_run;
    int k;
    int phase;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // calibration on reset register values; half the seeds push the offset past the limit
    @(posedge clk_i);
    idle_on = 1'b1;
    fault_run = $urandom_range(0, 1);
    for (k = 0; k < pewma_pkg::CalSamples; k++) begin
      if (fault_run) begin
        queue_sample(k == 0 ? 12'hFFF : pewma_pkg::SampleW'($urandom_range(1500, 4095)));
      end else begin
        queue_sample(k == 0 ? 12'h000 : pewma_pkg::SampleW'($urandom_range(0, 340)));
      end
    end
    queue_sample(12'h000);
    queue_sample(12'hFFF);
    queue_sample(12'h800);
    wait_drained();

    // weight above one, full-scale sensitivity and supply
    cfg_write(pewma_pkg::RegSmooth, 511);
    cfg_write(pewma_pkg::RegSens, 65535);
    cfg_write(pewma_pkg::RegSupply, 65535);
    cfg_write(pewma_pkg::RegLow, 65535);
    cfg_write(pewma_pkg::RegHigh, 0);
    @(posedge clk_i);
    queue_sample(12'hFFF);
    queue_sample(12'h000);
    queue_sample(12'hFFF);
    queue_sample(12'h001);
    wait_drained();

    for (phase = 0; phase < 8; phase++) begin
      random_config();
      random_phase(141, phase != 7 && $urandom_range(0, 3) != 0);
    end

    repeat (60) @(posedge clk_i);
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
